FILE: src/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the frame receiver RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fprb_pkg.sv
// -----------------------------------------------------------------------------
// fprb_pkg
// Types, constants and register codes shared by the frame receiver modules.
// -----------------------------------------------------------------------------
package fprb_pkg;

    // Default sizing of the buffer pool
    localparam int DEF_NUM_BUFFERS = 2;
    localparam int DEF_MAX_PAYLOAD = 255;

    // Reset values of the sync registers
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd34;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd105;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_SECOND = 1'b1;

    // Output stream payload width (66 bits used, padded to bytes)
    localparam int M_TDATA_W = 72;

    // Parser phase
    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    // Classified input item, as held in the front queue
    typedef struct packed {
        logic       is_read;
        logic [7:0] rx_byte;
        logic       hit_sync1;
        logic       hit_sync2;
        logic       len_ok;
    } t_item;

    // One result item
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [7:0]  frame_length;
        logic        last_byte;
        logic        flow_wait;
        logic [31:0] frames_received;
        logic [15:0] frames_dropped;
        logic        drop_event;
    } t_result;

endpackage

FILE: src/fprb_front.sv
// -----------------------------------------------------------------------------
// fprb_front
// Accepts input transfers, classifies each byte against the sync registers
// and the length range, and holds the items in a two-entry queue.
// -----------------------------------------------------------------------------
module fprb_front
    import fprb_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_sync_first,
    input  logic [7:0] i_sync_second,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    output logic       o_q_valid,
    input  logic       i_q_pop,
    output t_item      o_q_item
);

    t_item       r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    // Classify the incoming byte
    always_comb begin
        w_item.is_read   = i_func;
        w_item.rx_byte   = i_rx_byte;
        w_item.hit_sync1 = (i_rx_byte == i_sync_first);
        w_item.hit_sync2 = (i_rx_byte == i_sync_second);
        w_item.len_ok    = (i_rx_byte != 8'd0) && (i_rx_byte <= 8'(MAX_PAYLOAD));
    end

    assign o_ready   = (r_count != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign w_pop     = o_q_valid && i_q_pop;
    assign o_q_item  = r_q[r_rptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/fprb_back.sv
// -----------------------------------------------------------------------------
// fprb_back
// Runs the frame parser, buffer pool and read-out on one queued item per cycle
// unless the output stalls, and holds the result in an output register.
// -----------------------------------------------------------------------------
module fprb_back
    import fprb_pkg::*;
#(
    parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    output logic    o_q_pop,
    input  t_item   i_q_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int BUF_W     = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int MEM_DEPTH = NUM_BUFFERS * MAX_PAYLOAD;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Parser and pool state
    t_phase                 r_phase, n_phase;
    logic [NUM_BUFFERS-1:0] r_ready, n_ready;
    logic [7:0]             r_len [NUM_BUFFERS];
    logic [7:0]             r_mem [MEM_DEPTH];
    logic [7:0]             r_rd_data;
    logic [BUF_W-1:0]       r_fill_buf, n_fill_buf;
    logic [7:0]             r_fill_off, n_fill_off;
    logic [7:0]             r_fill_len, n_fill_len;
    logic                   r_rd_busy, n_rd_busy;
    logic [BUF_W-1:0]       r_rd_buf, n_rd_buf;
    logic [7:0]             r_rd_off, n_rd_off;
    logic [7:0]             r_rd_len, n_rd_len;
    logic [31:0]            r_rcv, n_rcv;
    logic [15:0]            r_drp, n_drp;

    // Output register
    logic        r_o_valid;
    logic        r_o_dv, n_o_dv;
    logic [7:0]  r_o_flen, n_o_flen;
    logic        r_o_last, n_o_last;
    logic        r_o_drop, n_o_drop;
    logic        r_o_wait;
    logic [31:0] r_o_rcv;
    logic [15:0] r_o_drp;

    logic              w_fire;
    logic              w_line;
    logic              w_rd;
    logic              w_free_found;
    logic [BUF_W-1:0]  w_free_idx;
    logic              w_rdy_found;
    logic [BUF_W-1:0]  w_rdy_idx;
    logic              w_fill_done;
    logic [BUF_W-1:0]  w_cur_buf;
    logic [7:0]        w_cur_len;
    logic [7:0]        w_cur_off;
    logic              w_cur_last;
    logic              w_len_we;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_wa;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_mem_ra;

    // Advance when the output register is free or being drained
    assign w_fire  = i_q_valid && (!r_o_valid || i_res_ready);
    assign o_q_pop = w_fire;
    assign w_line  = w_fire && !i_q_item.is_read;
    assign w_rd    = w_fire && i_q_item.is_read;

    // Lowest free and lowest ready buffer
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        w_rdy_found  = 1'b0;
        w_rdy_idx    = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (!r_ready[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = BUF_W'(i);
            end
            if (r_ready[i]) begin
                w_rdy_found = 1'b1;
                w_rdy_idx   = BUF_W'(i);
            end
        end
    end

    assign w_fill_done = ({1'b0, r_fill_off} + 9'd1) >= {1'b0, r_fill_len};

    // Read-out position: continue the open frame or start the lowest ready one
    assign w_cur_buf  = r_rd_busy ? r_rd_buf : w_rdy_idx;
    assign w_cur_len  = r_rd_busy ? r_rd_len : r_len[w_rdy_idx];
    assign w_cur_off  = r_rd_busy ? r_rd_off : 8'd0;
    assign w_cur_last = ({1'b0, w_cur_off} + 9'd1) >= {1'b0, w_cur_len};

    // Parser next phase
    always_comb begin
        n_phase = r_phase;
        if (w_line) begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (i_q_item.hit_sync1) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    priority if (i_q_item.hit_sync2) begin
                        n_phase = PH_LEN;
                    end else if (i_q_item.hit_sync1) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    priority if (!i_q_item.len_ok) begin
                        n_phase = PH_SYNC2;
                    end else if (!w_free_found) begin
                        n_phase = PH_SYNC1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (w_fill_done) begin
                        n_phase = PH_SYNC1;
                    end
                end
                default: n_phase = PH_SYNC1;
            endcase
        end
    end

    // Datapath actions of the current item
    always_comb begin
        n_ready    = r_ready;
        n_fill_buf = r_fill_buf;
        n_fill_off = r_fill_off;
        n_fill_len = r_fill_len;
        n_rd_busy  = r_rd_busy;
        n_rd_buf   = r_rd_buf;
        n_rd_off   = r_rd_off;
        n_rd_len   = r_rd_len;
        n_rcv      = r_rcv;
        n_drp      = r_drp;
        n_o_dv     = 1'b0;
        n_o_flen   = 8'd0;
        n_o_last   = 1'b0;
        n_o_drop   = 1'b0;
        w_len_we   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_mem_wa   = ADDR_W'(r_fill_buf) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(r_fill_off);
        w_mem_ra   = ADDR_W'(w_cur_buf) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(w_cur_off);

        if (w_line && (r_phase == PH_LEN) && i_q_item.len_ok) begin
            if (w_free_found) begin
                w_len_we   = 1'b1;
                n_fill_buf = w_free_idx;
                n_fill_len = i_q_item.rx_byte;
                n_fill_off = 8'd0;
            end else begin
                // Frame dropped: no free buffer
                n_fill_buf = '0;
                n_drp      = r_drp + 16'd1;
                n_o_drop   = 1'b1;
            end
        end

        if (w_line && (r_phase == PH_DATA)) begin
            w_mem_we   = 1'b1;
            n_fill_off = r_fill_off + 8'd1;
            if (w_fill_done) begin
                n_ready[r_fill_buf] = 1'b1;
                n_rcv               = r_rcv + 32'd1;
            end
        end

        if (w_rd) begin
            if (r_rd_busy || w_rdy_found) begin
                w_mem_re = 1'b1;
                n_o_dv   = 1'b1;
                n_o_flen = w_cur_len;
                if (w_cur_last) begin
                    n_o_last           = 1'b1;
                    n_ready[w_cur_buf] = 1'b0;
                    n_rd_busy          = 1'b0;
                    n_rd_off           = 8'd0;
                end else begin
                    n_rd_busy = 1'b1;
                    n_rd_buf  = w_cur_buf;
                    n_rd_len  = w_cur_len;
                    n_rd_off  = w_cur_off + 8'd1;
                end
            end else begin
                n_rd_busy = 1'b0;
                n_rd_off  = 8'd0;
            end
        end
    end

    // Payload store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= i_q_item.rx_byte;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_ra];
        end
    end

    // Frame lengths and datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_len[w_free_idx] <= i_q_item.rx_byte;
        end
        r_fill_len <= n_fill_len;
        r_rd_len   <= n_rd_len;
        if (w_fire) begin
            r_o_dv   <= n_o_dv;
            r_o_flen <= n_o_flen;
            r_o_last <= n_o_last;
            r_o_drop <= n_o_drop;
            r_o_wait <= &n_ready;
            r_o_rcv  <= n_rcv;
            r_o_drp  <= n_drp;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_ready    <= '0;
            r_fill_buf <= '0;
            r_fill_off <= 8'd0;
            r_rd_busy  <= 1'b0;
            r_rd_buf   <= '0;
            r_rd_off   <= 8'd0;
            r_rcv      <= 32'd0;
            r_drp      <= 16'd0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ready    <= n_ready;
            r_fill_buf <= n_fill_buf;
            r_fill_off <= n_fill_off;
            r_rd_busy  <= n_rd_busy;
            r_rd_buf   <= n_rd_buf;
            r_rd_off   <= n_rd_off;
            r_rcv      <= n_rcv;
            r_drp      <= n_drp;
            if (w_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result fields
    assign o_res_valid           = r_o_valid;
    assign o_res.data_valid      = r_o_dv;
    assign o_res.data_byte       = r_o_dv ? r_rd_data : 8'd0;
    assign o_res.frame_length    = r_o_flen;
    assign o_res.last_byte       = r_o_last;
    assign o_res.flow_wait       = r_o_wait;
    assign o_res.frames_received = r_o_rcv;
    assign o_res.frames_dropped  = r_o_drp;
    assign o_res.drop_event      = r_o_drop;

endmodule

FILE: src/framed_packet_receiver_buffers.sv
// A framed packet receiver: each input transfer is either a line byte
// (tuser 0) that is parsed for sync, sync, length, payload frames into a
// pool of NUM_BUFFERS frame buffers, or a read step (tuser 1) that returns
// the next payload byte of the open frame, else of the lowest ready frame.
// Every input transfer yields exactly one output transfer, in order. One
// item is taken per clock cycle unless the output stalls; each item is held
// in the input queue, then goes through the parser and the payload store's
// registered read port into the output register. The payload store has one
// write port and one registered read port, and needs no clearing pass after reset.
// -----------------------------------------------------------------------------
// framed_packet_receiver_buffers
// Top level: configuration registers, front queue, back engine and stream
// output packing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_packet_receiver_buffers
    import fprb_pkg::*;
#(
    parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    input  logic                  s_axis_tuser,   // [0] func
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] data_byte, [15:8] frame_length, [16] flow_wait,
    // [48:17] frames_received, [64:49] frames_dropped, [65] drop_event
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tuser,   // [0] data_valid
    output logic                  m_axis_tlast    // last_byte
);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic       w_q_valid;
    logic       w_q_pop;
    t_item      w_q_item;
    t_result    w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                default:         r_sync_first  <= r_sync_first;
            endcase
        end
    end

    fprb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_rx_byte     (s_axis_tdata),
        .o_q_valid     (w_q_valid),
        .i_q_pop       (w_q_pop),
        .o_q_item      (w_q_item)
    );

    fprb_back #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_item    (w_q_item),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // Output packing
    assign m_axis_tdata = {6'd0,
                           w_res.drop_event,
                           w_res.frames_dropped,
                           w_res.frames_received,
                           w_res.flow_wait,
                           w_res.frame_length,
                           w_res.data_byte};
    assign m_axis_tuser = w_res.data_valid;
    assign m_axis_tlast = w_res.last_byte;

    // Checks
    `ASSERT_IMPL(a_last_has_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "last byte without payload data")
    `ASSERT_IMPL(a_idle_fields_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == 16'd0, "byte or length nonzero without payload data")
    `ASSERT_IMPL(a_drop_not_read, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[65], !m_axis_tuser && !m_axis_tlast, "drop reported on a read result")

endmodule

FILE: sim/framed_packet_receiver_buffers_check.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Frame receiver scoreboard
// Watches the config port and both stream channels. Each accepted input
// transfer is run through a cycle-free model of the deframer and buffer pool.
// The result of that transfer is queued, and every output transfer is checked
// field by field against the oldest queued result.
// -----------------------------------------------------------------------------

module framed_packet_receiver_buffers_check
    import fprb_pkg::*;
#(
    parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    input  logic                  i_s_tuser,   // [0] func
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] data_byte, [15:8] frame_length, [16] flow_wait,
    // [48:17] frames_received, [64:49] frames_dropped, [65] drop_event
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_m_tuser,   // [0] data_valid
    input  logic                  i_m_tlast,   // last_byte
    output int                    o_fail_count,
    output int                    o_pending
);

    // Model state
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    t_phase      phase;
    logic        buf_ready [NUM_BUFFERS];
    logic [7:0]  buf_len   [NUM_BUFFERS];
    logic [7:0]  payload   [NUM_BUFFERS*MAX_PAYLOAD];
    int          fill_idx;
    int          fill_pos;
    logic        reading;
    int          read_idx;
    int          read_pos;
    logic [31:0] done_frames;
    logic [15:0] lost_frames;

    t_result     result_q [$];
    int          fail_count = 0;
    int          pend = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pend;

    function automatic logic pool_full();
        int i;
        for (i = 0; i < NUM_BUFFERS; i++)
            if (!buf_ready[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Lowest buffer whose ready flag equals want, NUM_BUFFERS if none
    function automatic int lowest_with(input logic want);
        int i;
        for (i = 0; i < NUM_BUFFERS; i++)
            if (buf_ready[i] == want) return i;
        return NUM_BUFFERS;
    endfunction

    // Frame parser for one line byte; returns 1 when the frame is dropped
    function automatic logic parse_byte(input logic [7:0] c);
        int   b;
        logic dropped;
        dropped = 1'b0;
        case (phase)
            PH_SYNC1: begin
                if (c == sync_a) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // second sync wins when both registers match
                if (c == sync_b) phase = PH_LEN;
                else if (c == sync_a) phase = PH_SYNC2;
                else phase = PH_SYNC1;
            end
            PH_LEN: begin
                if (c == 8'd0 || c > MAX_PAYLOAD) begin
                    phase = PH_SYNC2;
                end else begin
                    b = lowest_with(1'b0);
                    if (b >= NUM_BUFFERS) begin
                        fill_idx    = 0;
                        phase       = PH_SYNC1;
                        lost_frames = lost_frames + 16'd1;
                        dropped     = 1'b1;
                    end else begin
                        fill_idx   = b;
                        buf_len[b] = c;
                        fill_pos   = 0;
                        phase      = PH_DATA;
                    end
                end
            end
            default: begin
                if (fill_idx < NUM_BUFFERS && fill_pos < MAX_PAYLOAD) begin
                    payload[fill_idx*MAX_PAYLOAD + fill_pos] = c;
                    fill_pos++;
                    if (fill_pos >= buf_len[fill_idx]) begin
                        buf_ready[fill_idx] = 1'b1;
                        phase               = PH_SYNC1;
                        done_frames         = done_frames + 32'd1;
                    end
                end else begin
                    phase = PH_SYNC1;
                end
            end
        endcase
        return dropped;
    endfunction

    // Advance the model by one input transfer and build its result
    function automatic t_result predict_transfer(input logic is_read, input logic [7:0] c);
        t_result r;
        int      b;
        r = '0;
        if (!is_read) begin
            r.drop_event = parse_byte(c);
        end else begin
            if (!reading) begin
                b = lowest_with(1'b1);
                if (b < NUM_BUFFERS) begin
                    read_idx = b;
                    read_pos = 0;
                    reading  = 1'b1;
                end
            end
            if (reading && read_idx < NUM_BUFFERS && read_pos < MAX_PAYLOAD) begin
                r.data_valid   = 1'b1;
                r.data_byte    = payload[read_idx*MAX_PAYLOAD + read_pos];
                r.frame_length = buf_len[read_idx];
                read_pos++;
                if (read_pos >= buf_len[read_idx]) begin
                    r.last_byte         = 1'b1;
                    buf_ready[read_idx] = 1'b0;
                    reading             = 1'b0;
                    read_pos            = 0;
                end
            end else begin
                reading  = 1'b0;
                read_pos = 0;
            end
        end
        r.flow_wait       = pool_full();
        r.frames_received = done_frames;
        r.frames_dropped  = lost_frames;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (result_q.size() == 0) begin
            $error("output transfer with no input outstanding");
            fail_count++;
        end else begin
            want = result_q.pop_front();
            check_field("data_valid", 32'(want.data_valid), 32'(i_m_tuser));
            check_field("data_byte", 32'(want.data_byte), 32'(i_m_tdata[7:0]));
            check_field("frame_length", 32'(want.frame_length), 32'(i_m_tdata[15:8]));
            check_field("last_byte", 32'(want.last_byte), 32'(i_m_tlast));
            check_field("flow_wait", 32'(want.flow_wait), 32'(i_m_tdata[16]));
            check_field("frames_received", want.frames_received, i_m_tdata[48:17]);
            check_field("frames_dropped", 32'(want.frames_dropped), 32'(i_m_tdata[64:49]));
            check_field("drop_event", 32'(want.drop_event), 32'(i_m_tdata[65]));
        end
    endtask

    // Outputs are checked before the same edge's input is modeled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_a      = SYNC_FIRST_RST;
            sync_b      = SYNC_SECOND_RST;
            phase       = PH_SYNC1;
            fill_idx    = 0;
            fill_pos    = 0;
            reading     = 1'b0;
            read_idx    = 0;
            read_pos    = 0;
            done_frames = '0;
            lost_frames = '0;
            foreach (buf_ready[i]) begin
                buf_ready[i] = 1'b0;
                buf_len[i]   = '0;
            end
            result_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SYNC_FIRST:  sync_a = i_cfg_wdata;
                    CFG_SYNC_SECOND: sync_b = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(predict_transfer(i_s_tuser, i_s_tdata));
        end
        pend = result_q.size();
    end

endmodule

FILE: sim/framed_packet_receiver_buffers_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Frame receiver testbench
// Drives line bytes and read steps into the frame receiver: a short directed
// run through the corner cases, then random frames, broken frames, noise and
// read bursts under several sync settings and handshake stall patterns. The
// scoreboard beside the block checks every output transfer.
// -----------------------------------------------------------------------------

module framed_packet_receiver_buffers_test;
    import fprb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PART_ITEMS   = 100;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_SYNC_FIRST;
    logic [7:0]            i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int         fail_count;
    int         pending;
    int         feed_gap_pct    = 0;
    int         drain_stall_pct = 0;
    logic       hold_req        = 1'b0;
    logic       rx_hold         = 1'b0;
    logic [7:0] cur_first       = SYNC_FIRST_RST;
    logic [7:0] cur_second      = SYNC_SECOND_RST;
    int         items_sent      = 0;
    int         cycle_count     = 0;

    framed_packet_receiver_buffers dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    framed_packet_receiver_buffers_check scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: random stalls, or a forced hold-off
    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= drain_stall_pct);
    end

    // Long hold-off of the output side, once
    initial begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One input transfer, with random gaps ahead of it
    task automatic send_item(input logic rd, input logic [7:0] b);
        while ($urandom_range(99) < feed_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rd;
        s_axis_tdata  <= b;
        items_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_line(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    // rx_byte is don't-care on a read step, so it carries random bits
    task automatic send_read();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic send_frame(input int len);
        send_line(cur_first);
        send_line(cur_second);
        send_line(8'(len));
        repeat (len) send_line(8'($urandom));
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_syncs(input logic [7:0] first_byte, input logic [7:0] second_byte);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SYNC_FIRST;
        i_cfg_wdata <= first_byte;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SYNC_SECOND;
        i_cfg_wdata <= second_byte;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_first  = first_byte;
        cur_second = second_byte;
    endtask

    // One random sequence: mostly clean frames and read bursts
    task automatic random_group();
        int pick;
        int len;
        int n;
        pick = $urandom_range(99);
        len  = ($urandom_range(99) == 0) ? $urandom_range(255, 200) : $urandom_range(8, 1);
        n    = $urandom_range(12, 1);
        if (pick < 45) begin
            send_frame(len);
        end else if (pick < 77) begin
            repeat (n) send_read();
        end else if (pick < 83) begin
            // zero length, then the frame picks up again at the second sync
            send_line(cur_first);
            send_line(cur_second);
            send_line(8'd0);
            send_line(cur_second);
            send_line(8'(len));
            repeat (len) send_line(8'($urandom));
        end else if (pick < 87) begin
            // first sync twice
            send_line(cur_first);
            send_frame(len);
        end else if (pick < 91) begin
            // frame cut short; whatever follows fills it up
            send_line(cur_first);
            send_line(cur_second);
            send_line(8'(n));
            repeat ($urandom_range(n - 1)) send_line(8'($urandom));
        end else if (pick < 95) begin
            // first sync followed by a random byte
            send_line(cur_first);
            send_line(8'($urandom));
        end else begin
            repeat ($urandom_range(4, 1)) send_line(8'($urandom));
        end
    endtask

    task automatic random_part(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_group();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: read with nothing ready, then byte extremes as noise
        send_read();
        send_line(8'h00);
        send_line(8'hFF);
        // first sync twice, zero length, resume at second sync, 1-byte frame
        send_line(cur_first);
        send_line(cur_first);
        send_line(cur_second);
        send_line(8'd0);
        send_line(cur_second);
        send_line(8'd1);
        send_line(8'hFF);
        // second frame fills the pool
        send_line(cur_first);
        send_line(cur_second);
        send_line(8'd2);
        send_line(8'h00);
        send_line(8'h80);
        // no free buffer: dropped, payload parsed as line bytes
        send_line(cur_first);
        send_line(cur_second);
        send_line(8'd3);
        send_line(8'hAA);
        // read both frames out, then one read with nothing ready
        repeat (4) send_read();

        // Slow output side
        feed_gap_pct    = 22;
        drain_stall_pct = 83;
        set_syncs(8'd0, 8'd255);
        random_part(PART_ITEMS);
        set_syncs(8'd255, 8'd0);
        random_part(PART_ITEMS);

        // Slow input side, equal sync bytes
        feed_gap_pct    = 83;
        drain_stall_pct = 22;
        set_syncs(8'd0, 8'd0);
        random_part(PART_ITEMS);
        set_syncs(8'd255, 8'd255);
        random_part(PART_ITEMS);

        // Full rate; output held off while a maximum-length frame is offered
        feed_gap_pct    = 0;
        drain_stall_pct = 0;
        set_syncs(8'd90, 8'd90);
        hold_req = 1'b1;
        send_frame(255);
        random_part(PART_ITEMS);
        set_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST);
        random_part(PART_ITEMS);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: framed_packet_receiver_buffers.f
+incdir+src
src/fprb_pkg.sv
src/fprb_front.sv
src/fprb_back.sv
src/framed_packet_receiver_buffers.sv
sim/framed_packet_receiver_buffers_check.sv
sim/framed_packet_receiver_buffers_test.sv
